// ----- rtl/ipid_pkg.sv -----
// ---------------------------------------------------------------------------
// Incremental PID controller package
// Widths, register indexes, reset values and the types that pass between
// the stages of the controller.
// ---------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

	// Field and datapath widths.
	localparam int SAMPLE_W = 16;   // reference and feedback
	localparam int GAIN_W   = 24;   // unsigned Q8.16 gains
	localparam int LIMIT_W  = 16;   // ranges and clamp limits
	localparam int ERR_W    = 17;   // reference - feedback
	localparam int D1_W     = 18;   // first difference
	localparam int D2_W     = 19;   // second difference
	localparam int FRAC_W   = 16;   // fractional bits of the accumulator
	localparam int ACC_W    = 32;   // Q16.16 accumulator
	localparam int PROD_P_W = GAIN_W + 1 + D1_W;
	localparam int PROD_I_W = GAIN_W + 1 + ERR_W;
	localparam int PROD_D_W = GAIN_W + 1 + D2_W;
	localparam int SUM_W    = 46;   // accumulator plus three products, exact

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GAIN_W;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REFERENCE   = 3'd0,
		REG_PROP_GAIN   = 3'd1,
		REG_INTEG_GAIN  = 3'd2,
		REG_DERIV_GAIN  = 3'd3,
		REG_INTEG_RANGE = 3'd4,
		REG_DERIV_RANGE = 3'd5,
		REG_OUT_MAX     = 3'd6,
		REG_OUT_MIN     = 3'd7
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic signed [SAMPLE_W-1:0] RST_REFERENCE   = 16'sd4500;
	localparam logic [GAIN_W-1:0]          RST_PROP_GAIN   = 24'd655360;
	localparam logic [GAIN_W-1:0]          RST_INTEG_GAIN  = 24'd13107;
	localparam logic [GAIN_W-1:0]          RST_DERIV_GAIN  = 24'd655;
	localparam logic [LIMIT_W-1:0]         RST_INTEG_RANGE = 16'd200;
	localparam logic [LIMIT_W-1:0]         RST_DERIV_RANGE = 16'd100;
	localparam logic [LIMIT_W-1:0]         RST_OUT_MAX     = 16'd7200;
	localparam logic [LIMIT_W-1:0]         RST_OUT_MIN     = 16'd800;

	// Configuration register file contents.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] reference;
		logic [GAIN_W-1:0]          prop_gain;
		logic [GAIN_W-1:0]          integ_gain;
		logic [GAIN_W-1:0]          deriv_gain;
		logic [LIMIT_W-1:0]         integ_range;
		logic [LIMIT_W-1:0]         deriv_range;
		logic [LIMIT_W-1:0]         out_max;
		logic [LIMIT_W-1:0]         out_min;
	} cfg_t;

	// Error terms and term enables, first stage to second.
	typedef struct packed {
		logic signed [ERR_W-1:0] err;
		logic signed [D1_W-1:0]  d1;
		logic signed [D2_W-1:0]  d2;
		logic                    integ_en;
		logic                    deriv_en;
	} err_terms_t;

	// Gain products, second stage to third.
	typedef struct packed {
		logic signed [PROD_P_W-1:0] prop;
		logic signed [PROD_I_W-1:0] integ;
		logic signed [PROD_D_W-1:0] deriv;
		logic                       integ_en;
		logic                       deriv_en;
	} prod_t;

endpackage

`default_nettype wire

// ----- rtl/ipid_err.sv -----
// ---------------------------------------------------------------------------
// Error stage
// Forms the error, its first and second differences and the term enables,
// and keeps the previous error and previous first difference.
// ---------------------------------------------------------------------------
`default_nettype none

module ipid_err (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire ipid_pkg::cfg_t                   cfg,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic signed [ipid_pkg::SAMPLE_W-1:0] feedback,
	output logic                                  valid_s1,
	output ipid_pkg::err_terms_t                  terms_s1,
	input  wire logic                             next_ready
);
	import ipid_pkg::*;

	logic                    ready;
	logic                    accept;
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [D1_W-1:0]  prev_d1_q;
	logic signed [ERR_W-1:0] err;
	logic signed [D1_W-1:0]  d1;
	logic signed [D2_W-1:0]  d2;
	logic signed [D1_W-1:0]  err_wide;
	logic [ERR_W-1:0]        mag;
	logic [ERR_W-1:0]        integ_lim;
	logic [ERR_W-1:0]        deriv_lim;

	// The stage takes a new sample when it is empty or its item moves on.
	assign ready    = !valid_s1 || next_ready;
	assign in_stall = !ready;
	assign accept   = in_valid && ready;

	// Error, differences and magnitude.
	always_comb begin
		err       = ERR_W'(cfg.reference) - ERR_W'(feedback);
		d1        = D1_W'(err) - D1_W'(prev_err_q);
		d2        = D2_W'(d1) - D2_W'(prev_d1_q);
		err_wide  = D1_W'(err);
		mag       = err_wide[D1_W-1] ? ERR_W'(-err_wide) : ERR_W'(err_wide);
		integ_lim = ERR_W'(cfg.integ_range);
		deriv_lim = ERR_W'(cfg.deriv_range);
	end

	// History of the error sequence advances with every accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			prev_d1_q  <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				prev_err_q <= err;
				prev_d1_q  <= d1;
			end
			if (ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk) begin
		if (accept) begin
			terms_s1.err      <= err;
			terms_s1.d1       <= d1;
			terms_s1.d2       <= d2;
			terms_s1.integ_en <= (cfg.integ_range == '0) || (mag < integ_lim);
			terms_s1.deriv_en <= (cfg.deriv_range == '0) || (mag > deriv_lim);
		end
	end

	// The stored history always matches the terms of the last accepted sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (prev_err_q == terms_s1.err) && (prev_d1_q == terms_s1.d1))
		else $error("error history out of step with stage register");

	// A stalled stage keeps its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !next_ready) |=> valid_s1 && $stable(terms_s1))
		else $error("error stage lost a stalled item");

	// The second difference is the step of the first difference.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (D2_W'(terms_s1.d1) - D2_W'($past(prev_d1_q))) == terms_s1.d2)
		else $error("second difference mismatch");

endmodule

`default_nettype wire

// ----- rtl/ipid_mul.sv -----
// ---------------------------------------------------------------------------
// Gain multiply stage
// Multiplies the three error terms by their unsigned Q8.16 gains.
// ---------------------------------------------------------------------------
`default_nettype none

module ipid_mul (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ipid_pkg::cfg_t       cfg,
	input  wire logic                 valid_s1,
	input  wire ipid_pkg::err_terms_t terms_s1,
	output logic                      ready_s1,
	output logic                      valid_s2,
	output ipid_pkg::prod_t           prod_s2,
	input  wire logic                 next_ready
);
	import ipid_pkg::*;

	logic                       load;
	logic signed [GAIN_W:0]     kp;
	logic signed [GAIN_W:0]     ki;
	logic signed [GAIN_W:0]     kd;
	logic signed [PROD_P_W-1:0] prop;
	logic signed [PROD_I_W-1:0] integ;
	logic signed [PROD_D_W-1:0] deriv;

	assign ready_s1 = !valid_s2 || next_ready;
	assign load     = valid_s1 && ready_s1;

	// Three independent signed products; each gain gets a zero sign bit.
	always_comb begin
		kp    = $signed({1'b0, cfg.prop_gain});
		ki    = $signed({1'b0, cfg.integ_gain});
		kd    = $signed({1'b0, cfg.deriv_gain});
		prop  = PROD_P_W'(kp) * PROD_P_W'(terms_s1.d1);
		integ = PROD_I_W'(ki) * PROD_I_W'(terms_s1.err);
		deriv = PROD_D_W'(kd) * PROD_D_W'(terms_s1.d2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	// Product register.
	always_ff @(posedge clk) begin
		if (load) begin
			prod_s2.prop     <= prop;
			prod_s2.integ    <= integ;
			prod_s2.deriv    <= deriv;
			prod_s2.integ_en <= terms_s1.integ_en;
			prod_s2.deriv_en <= terms_s1.deriv_en;
		end
	end

	// Enables travel unchanged with their products.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (prod_s2.integ_en == $past(terms_s1.integ_en))
			&& (prod_s2.deriv_en == $past(terms_s1.deriv_en)))
		else $error("term enables lost in multiply stage");

	// A stalled product stage keeps its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !next_ready) |=> valid_s2 && $stable(prod_s2))
		else $error("multiply stage lost a stalled item");

	// A zero error gives a zero integral product.
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && (terms_s1.err == '0)) |=> (prod_s2.integ == '0))
		else $error("integral product wrong for zero error");

endmodule

`default_nettype wire

// ----- rtl/ipid_acc.sv -----
// ---------------------------------------------------------------------------
// Accumulate and clamp stage
// Adds the proportional product and the enabled integral and derivative
// products to the Q16.16 accumulator, clamps the sum and presents its integer part as the result.
// ---------------------------------------------------------------------------
`default_nettype none

module ipid_acc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ipid_pkg::cfg_t                cfg,
	input  wire logic                          valid_s2,
	input  wire ipid_pkg::prod_t               prod_s2,
	output logic                               ready_s2,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [ipid_pkg::LIMIT_W-1:0]       drive
);
	import ipid_pkg::*;

	logic                    load;
	logic [ACC_W-1:0]        accum_q;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] hi;
	logic signed [SUM_W-1:0] lo;
	logic signed [SUM_W-1:0] clamped;

	// The result register accepts an item once the held result is gone.
	assign ready_s2 = !out_valid || !out_stall;
	assign load     = valid_s2 && ready_s2;

	// Exact sum, then clamp with the maximum checked first.
	always_comb begin
		hi  = $signed({(SUM_W-ACC_W)'(0), cfg.out_max, FRAC_W'(0)});
		lo  = $signed({(SUM_W-ACC_W)'(0), cfg.out_min, FRAC_W'(0)});
		sum = $signed({(SUM_W-ACC_W)'(0), accum_q}) + SUM_W'(prod_s2.prop);
		if (prod_s2.integ_en) begin
			sum = sum + SUM_W'(prod_s2.integ);
		end
		if (prod_s2.deriv_en) begin
			sum = sum + SUM_W'(prod_s2.deriv);
		end
		if (sum > hi) begin
			clamped = hi;
		end else if (sum < lo) begin
			clamped = lo;
		end else begin
			clamped = sum;
		end
	end

	// Accumulator doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				accum_q <= clamped[ACC_W-1:0];
			end
			if (ready_s2) begin
				out_valid <= valid_s2;
			end
		end
	end

	assign drive = accum_q[ACC_W-1:FRAC_W];

	// A fresh result never exceeds the maximum unless it was pulled up to the minimum.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (drive <= $past(cfg.out_max)) || (drive == $past(cfg.out_min)))
		else $error("result above upper clamp");

	// A fresh result never falls below the minimum unless it was set to the maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (drive >= $past(cfg.out_min)) || (drive == $past(cfg.out_max)))
		else $error("result below lower clamp");

	// The accumulator only moves when an item is taken in.
	assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(accum_q))
		else $error("accumulator changed without an item");

endmodule

`default_nettype wire

// ----- rtl/incremental_pid_controller.sv -----
// ---------------------------------------------------------------------------
// Incremental PID controller
// Each feedback sample updates a Q16.16 output accumulator by the
// proportional, integral and derivative increments; the clamped integer
// part of the accumulator is the drive value.
//
// Input channel: feedback with in_valid / in_stall; a sample transfers on
// a rising edge with in_valid high and in_stall low.
// Output channel: drive with out_valid / out_stall, same rule.
// Configuration: cfg_valid / cfg_ready write channel, cfg_index selects a
// register, cfg_data carries the value; cfg_ready is always high. Write
// registers only while no sample is in flight.
// Stages: the error stage, the multiply stage and the accumulate and clamp
// stage, each registered, lie between input transfer and out_valid.
// Throughput: one sample per cycle while out_stall is low; the accumulator
// update closes its feedback loop within the last stage.
// Reset: clears the history, the accumulator and all valid flags, and
// loads the register defaults. A stall on the output holds the result and
// backs up through the stages to in_stall.
// ---------------------------------------------------------------------------
`default_nettype none

module incremental_pid_controller (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [ipid_pkg::SAMPLE_W-1:0] feedback,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [ipid_pkg::LIMIT_W-1:0]              drive,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [ipid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ipid_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ipid_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	err_terms_t terms_s1;
	logic       ready_s1;
	logic       valid_s2;
	prod_t      prod_s2;
	logic       ready_s2;

	assign cfg_ready = 1'b1;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reference   <= RST_REFERENCE;
			cfg_q.prop_gain   <= RST_PROP_GAIN;
			cfg_q.integ_gain  <= RST_INTEG_GAIN;
			cfg_q.deriv_gain  <= RST_DERIV_GAIN;
			cfg_q.integ_range <= RST_INTEG_RANGE;
			cfg_q.deriv_range <= RST_DERIV_RANGE;
			cfg_q.out_max     <= RST_OUT_MAX;
			cfg_q.out_min     <= RST_OUT_MIN;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REFERENCE:   cfg_q.reference   <= $signed(cfg_data[SAMPLE_W-1:0]);
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_RANGE: cfg_q.integ_range <= cfg_data[LIMIT_W-1:0];
				REG_DERIV_RANGE: cfg_q.deriv_range <= cfg_data[LIMIT_W-1:0];
				REG_OUT_MAX:     cfg_q.out_max     <= cfg_data[LIMIT_W-1:0];
				REG_OUT_MIN:     cfg_q.out_min     <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Error and difference stage.
	ipid_err u_err (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.feedback   (feedback),
		.valid_s1   (valid_s1),
		.terms_s1   (terms_s1),
		.next_ready (ready_s1)
	);

	// Gain multiply stage.
	ipid_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.valid_s1   (valid_s1),
		.terms_s1   (terms_s1),
		.ready_s1   (ready_s1),
		.valid_s2   (valid_s2),
		.prod_s2    (prod_s2),
		.next_ready (ready_s2)
	);

	// Accumulate, clamp and result stage.
	ipid_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.valid_s2  (valid_s2),
		.prod_s2   (prod_s2),
		.ready_s2  (ready_s2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

	// Without an output stall the pipeline never pushes back on the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	// An input stall means every stage holds an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_valid && out_stall)
		else $error("input stalled with a free stage");

	// A sample taken in passes the error, multiply and accumulate stages to out_valid if nothing stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |-> ##1 out_valid)
		else $error("sample did not reach the output");

endmodule

`default_nettype wire
